/* rtl/core/gcd_pkg.sv */
`default_nettype none

package gcd_pkg;

    // Angle lanes that run through the sine/cosine cell rows.
    localparam int LANES    = 4;
    localparam int LN_DLAT  = 0;
    localparam int LN_DLON  = 1;
    localparam int LN_LAT_A = 2;
    localparam int LN_LAT_B = 3;

    localparam int SQRT_STEPS = 32;

    // Angles in units of 2^-17 degree.
    localparam logic [25:0] DEG90  = 26'd11796480;
    localparam logic [25:0] DEG180 = 26'd23592960;

    // floor(floor(pi * 2^60) / 2^20 / 180): degrees (2^-17) to Q30 radians after >> 27.
    localparam logic [34:0] KRAD = 35'd19190098068;

    localparam logic [32:0] INV_GAIN = 33'h026DD3B6A;
    localparam logic [30:0] HALF_PI  = 31'h6487ED51;
    localparam logic [30:0] ONE_Q30  = 31'h40000000;
    localparam logic [13:0] DIAMETER = 14'd12746;
    localparam logic [44:0] ROUND_HALF = 45'd2097152;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_cordic;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sqrt;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:  t = 32'h3243F6A8;
            5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;
            5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;
            5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;
            5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;
            5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;
            5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;
            5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;
            5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;
            5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;
            5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;
            5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;
            5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;
            5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;
            5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004;
            5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gcd_if.sv */
`default_nettype none

interface gcd_in_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_b;
    logic signed [23:0] lat_b;

    modport source (output valid, output lon_a, output lat_a, output lon_b, output lat_b,
                    input ready);
    modport sink (input valid, input lon_a, input lat_a, input lon_b, input lat_b,
                  output ready);
endinterface

interface gcd_out_if;
    logic        valid;
    logic        ready;
    logic [22:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

`default_nettype wire

/* rtl/core/gcd_rot_cell.sv */
`default_nettype none

module gcd_rot_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  gcd_pkg::t_cordic i_d,
    output gcd_pkg::t_cordic o_d
);

    gcd_pkg::t_cordic   r_d;
    gcd_pkg::t_cordic   n_d;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic signed [32:0] w_at;

    always_comb begin
        w_dx = i_d.y >>> STEP;
        w_dy = i_d.x >>> STEP;
        w_at = 33'(gcd_pkg::atan_q30(5'(STEP)));
        if (!i_d.z[32]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - w_at;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* rtl/core/gcd_vec_cell.sv */
`default_nettype none

module gcd_vec_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  gcd_pkg::t_cordic i_d,
    output gcd_pkg::t_cordic o_d
);

    gcd_pkg::t_cordic   r_d;
    gcd_pkg::t_cordic   n_d;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic signed [32:0] w_at;

    // Drives y toward zero; z collects the angle of the input vector.
    always_comb begin
        w_dx = i_d.y >>> STEP;
        w_dy = i_d.x >>> STEP;
        w_at = 33'(gcd_pkg::atan_q30(5'(STEP)));
        if (!i_d.y[32]) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + w_at;
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* rtl/core/gcd_sqrt_cell.sv */
`default_nettype none

module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  gcd_pkg::t_sqrt i_d,
    output gcd_pkg::t_sqrt o_d
);

    localparam logic [63:0] DIGIT = 64'd1 << (62 - 2 * STEP);

    gcd_pkg::t_sqrt r_d;
    gcd_pkg::t_sqrt n_d;
    logic [63:0]    w_trial;

    always_comb begin
        w_trial = i_d.r + DIGIT;
        if (i_d.v >= w_trial) begin
            n_d.v = i_d.v - w_trial;
            n_d.r = (i_d.r >> 1) + DIGIT;
        end else begin
            n_d.v = i_d.v;
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* rtl/core/great_circle_distance.sv */
`default_nettype none

// Channel   Direction  Payload                          Transaction
// i_pt      in         lon_a, lat_a, lon_b, lat_b       valid && ready
// o_dist    out        distance (km * 256)              valid && ready
//
// One transaction is taken per cycle while the pipeline advances; each result passes
// the CORDIC rotation rows, the 32-cell square root row and the CORDIC vectoring row.
// The whole pipeline advances together; it holds only while a finished result
// sits in the output register and the sink is not ready.
// Reset (i_rst_n low, synchronous) clears the valid bits only.

module great_circle_distance #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gcd_in_if.sink         i_pt,
    gcd_out_if.source      o_dist
);

    localparam int N      = CORDIC_STEPS;
    localparam int LAT    = 2 * CORDIC_STEPS + 43;
    localparam int NX_LEN = CORDIC_STEPS + 5;
    localparam int VLD_SQ = CORDIC_STEPS + 40;
    localparam int SQN    = gcd_pkg::SQRT_STEPS;
    localparam int LN     = gcd_pkg::LANES;

    localparam logic [17:0] KHI = gcd_pkg::KRAD[34:17];
    localparam logic [16:0] KLO = gcd_pkg::KRAD[16:0];

    logic             w_en;
    logic [LAT-1:0]   r_vld;
    logic [NX_LEN-1:0] r_nx;

    // Input register.
    logic signed [24:0] r_s0_lon_a;
    logic signed [23:0] r_s0_lat_a;
    logic signed [24:0] r_s0_lon_b;
    logic signed [23:0] r_s0_lat_b;

    logic signed [26:0] w_s1_d [LN];
    logic [25:0]        n_s1_m [LN];
    logic [25:0]        r_s1_m [LN];
    logic [25:0]        n_s2_m [LN];
    logic [25:0]        r_s2_m [LN];
    logic [LN-1:0]      w_s3_f;
    logic [23:0]        n_s3_u [LN];
    logic [23:0]        r_s3_u [LN];
    logic [41:0]        n_s4_ph [LN];
    logic [41:0]        r_s4_ph [LN];
    logic [40:0]        n_s4_pl [LN];
    logic [40:0]        r_s4_pl [LN];
    logic [58:0]        w_s5_sum [LN];
    logic [30:0]        n_s5_z [LN];
    logic [30:0]        r_s5_z [LN];

    gcd_pkg::t_cordic   w_rot [LN][N+1];

    logic [31:0]        w_m1_sa;
    logic [31:0]        w_m1_so;
    logic [31:0]        w_m1_ca;
    logic [31:0]        w_m1_cb;
    logic [31:0]        n_m1_t1;
    logic [31:0]        n_m1_sl;
    logic [31:0]        n_m1_cc;
    logic [31:0]        r_m1_t1;
    logic [31:0]        r_m1_sl;
    logic [31:0]        r_m1_cc;
    logic [33:0]        n_m2_t2;
    logic [33:0]        r_m2_t2;
    logic [31:0]        r_m2_t1;
    logic signed [35:0] w_m3_a;
    logic [30:0]        n_m3_a;
    logic [30:0]        r_m3_a;

    gcd_pkg::t_sqrt     w_sqy [SQN+1];
    gcd_pkg::t_sqrt     w_sqx [SQN+1];
    gcd_pkg::t_cordic   w_vec [N+1];

    logic signed [32:0] w_f1_z;
    logic [30:0]        n_f1_z;
    logic [30:0]        r_f1_z;
    logic [44:0]        w_f2_p;
    logic [22:0]        r_f2_d;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] t;
        t = v[32] ? 33'(-v) : 33'(v);
        return t[31:0];
    endfunction

    assign w_en         = !r_vld[LAT-1] || o_dist.ready;
    assign i_pt.ready   = w_en;
    assign o_dist.valid = r_vld[LAT-1];
    assign o_dist.distance = r_f2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    // Half differences and doubled latitudes, all in 2^-17 degree, as magnitudes.
    always_comb begin
        w_s1_d[gcd_pkg::LN_DLAT]  = 27'(r_s0_lat_b) - 27'(r_s0_lat_a);
        w_s1_d[gcd_pkg::LN_DLON]  = 27'(r_s0_lon_b) - 27'(r_s0_lon_a);
        w_s1_d[gcd_pkg::LN_LAT_A] = 27'(r_s0_lat_a) <<< 1;
        w_s1_d[gcd_pkg::LN_LAT_B] = 27'(r_s0_lat_b) <<< 1;
        for (int k = 0; k < LN; k++) begin
            n_s1_m[k] = w_s1_d[k][26] ? 26'(-w_s1_d[k]) : 26'(w_s1_d[k]);
        end
    end

    // Every magnitude is below twice 180 degrees, and doubled latitudes stay below
    // 180 degrees, so one subtract gives the reduction and one fold maps into [0,90].
    always_comb begin
        for (int k = 0; k < LN; k++) begin
            n_s2_m[k] = (r_s1_m[k] >= gcd_pkg::DEG180) ? r_s1_m[k] - gcd_pkg::DEG180
                                                        : r_s1_m[k];
            w_s3_f[k] = r_s2_m[k] > gcd_pkg::DEG90;
            n_s3_u[k] = w_s3_f[k] ? 24'(gcd_pkg::DEG180 - r_s2_m[k]) : 24'(r_s2_m[k]);
            n_s4_ph[k] = 42'(r_s3_u[k]) * 42'(KHI);
            n_s4_pl[k] = 41'(r_s3_u[k]) * 41'(KLO);
            w_s5_sum[k] = (59'(r_s4_ph[k]) << 17) + 59'(r_s4_pl[k]);
            n_s5_z[k] = w_s5_sum[k][57:27];
        end
    end

    always_comb begin
        w_m1_sa = mag33(w_rot[gcd_pkg::LN_DLAT][N].y);
        w_m1_so = mag33(w_rot[gcd_pkg::LN_DLON][N].y);
        w_m1_ca = mag33(w_rot[gcd_pkg::LN_LAT_A][N].x);
        w_m1_cb = mag33(w_rot[gcd_pkg::LN_LAT_B][N].x);
        n_m1_t1 = 32'((64'(w_m1_sa) * 64'(w_m1_sa)) >> 30);
        n_m1_sl = 32'((64'(w_m1_so) * 64'(w_m1_so)) >> 30);
        n_m1_cc = 32'((64'(w_m1_ca) * 64'(w_m1_cb)) >> 30);
        n_m2_t2 = 34'((64'(r_m1_cc) * 64'(r_m1_sl)) >> 30);
    end

    // A latitude past 90 degrees has a negative cosine: when exactly one is, the product term subtracts.
    always_comb begin
        if (r_nx[NX_LEN-1]) begin
            w_m3_a = 36'(r_m2_t1) - 36'(r_m2_t2);
        end else begin
            w_m3_a = 36'(r_m2_t1) + 36'(r_m2_t2);
        end
        if (w_m3_a[35]) begin
            n_m3_a = '0;
        end else if (w_m3_a > 36'sh040000000) begin
            n_m3_a = gcd_pkg::ONE_Q30;
        end else begin
            n_m3_a = 31'(w_m3_a);
        end
    end

    always_comb begin
        w_f1_z = w_vec[N].z;
        if (w_f1_z[32]) begin
            n_f1_z = '0;
        end else if (w_f1_z > 33'(gcd_pkg::HALF_PI)) begin
            n_f1_z = gcd_pkg::HALF_PI;
        end else begin
            n_f1_z = w_f1_z[30:0];
        end
        w_f2_p = 45'(r_f1_z) * 45'(gcd_pkg::DIAMETER) + gcd_pkg::ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_lon_a <= i_pt.lon_a;
            r_s0_lat_a <= i_pt.lat_a;
            r_s0_lon_b <= i_pt.lon_b;
            r_s0_lat_b <= i_pt.lat_b;
            r_s1_m     <= n_s1_m;
            r_s2_m     <= n_s2_m;
            r_s3_u     <= n_s3_u;
            r_nx       <= {r_nx[NX_LEN-2:0],
                           w_s3_f[gcd_pkg::LN_LAT_A] ^ w_s3_f[gcd_pkg::LN_LAT_B]};
            r_s4_ph    <= n_s4_ph;
            r_s4_pl    <= n_s4_pl;
            r_s5_z     <= n_s5_z;
            r_m1_t1    <= n_m1_t1;
            r_m1_sl    <= n_m1_sl;
            r_m1_cc    <= n_m1_cc;
            r_m2_t1    <= r_m1_t1;
            r_m2_t2    <= n_m2_t2;
            r_m3_a     <= n_m3_a;
            r_f1_z     <= n_f1_z;
            r_f2_d     <= w_f2_p[44:22];
        end
    end

    // Four sine/cosine rows, one per angle lane.
    for (genvar l = 0; l < LN; l++) begin : g_lane
        assign w_rot[l][0] = '{x: signed'(gcd_pkg::INV_GAIN), y: '0,
                               z: signed'({2'b00, r_s5_z[l]})};
        for (genvar s = 0; s < N; s++) begin : g_rot
            gcd_rot_cell #(.STEP(s)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_rot[l][s]),
                .o_d   (w_rot[l][s+1])
            );
        end
    end

    assign w_sqy[0] = '{v: 64'(r_m3_a) << 30, r: '0};
    assign w_sqx[0] = '{v: 64'(gcd_pkg::ONE_Q30 - r_m3_a) << 30, r: '0};

    for (genvar s = 0; s < SQN; s++) begin : g_sqrt
        gcd_sqrt_cell #(.STEP(s)) u_sq_y (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sqy[s]),
            .o_d   (w_sqy[s+1])
        );
        gcd_sqrt_cell #(.STEP(s)) u_sq_x (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sqx[s]),
            .o_d   (w_sqx[s+1])
        );
    end

    assign w_vec[0] = '{x: signed'({2'b00, w_sqx[SQN].r[30:0]}),
                        y: signed'({2'b00, w_sqy[SQN].r[30:0]}), z: '0};

    for (genvar s = 0; s < N; s++) begin : g_vec
        gcd_vec_cell #(.STEP(s)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_vec[s]),
            .o_d   (w_vec[s+1])
        );
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_dist.valid)
        else $error("output valid right after reset");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[VLD_SQ] |-> (w_sqy[SQN].r <= 64'(gcd_pkg::ONE_Q30))
                       && (w_sqx[SQN].r <= 64'(gcd_pkg::ONE_Q30)))
        else $error("square root out of range");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist.valid |-> o_dist.distance <= 23'd5125471)
        else $error("distance beyond half circumference");

endmodule

`default_nettype wire

/* sim/gcd_checker.sv */
`default_nettype none

module gcd_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gcd_in_if      i_pt,
    gcd_out_if     o_dist,
    output int     o_errors,
    output int     o_pending
);

    localparam longint DEG_90  = 64'd11796480;
    localparam longint DEG_180 = 64'd23592960;
    localparam longint DEG_360 = 64'd47185920;
    localparam longint RAD_K   = 64'd19190098068;
    localparam longint Q30_ONE = 64'd1073741824;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    logic [22:0] dist_queue[$];

    function automatic int n_steps();
        return (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    endfunction

    function automatic longint angle_at(input int i);
        longint t[32] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
            64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
            64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
            64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
            64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004,
            64'h00000002, 64'h00000001, 64'h00000000};
        return t[i];
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint deg_to_rad(input longint u);
        longint unsigned p;
        p = longint'(u) * RAD_K;
        return longint'(p >> 27);
    endfunction

    // Rotation mode; arithmetic shifts floor toward minus infinity as required.
    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint x, y, dx, dy;
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < n_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x -= dx; y += dy; ang -= angle_at(i);
            end else begin
                x += dx; y -= dy; ang += angle_at(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < n_steps(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += angle_at(i);
            end else begin
                x -= dx; y += dy; z -= angle_at(i);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned half_sin_sq(input longint h);
        longint u, c, s;
        longint unsigned m;
        u = abs64(h) % DEG_180;
        if (u > DEG_90) u = DEG_180 - u;
        rotate(deg_to_rad(u), c, s);
        m = abs64(s);
        return (m * m) >> 30;
    endfunction

    function automatic longint unsigned lat_cos(input longint lat, output bit neg);
        longint u, c, s;
        u = abs64(lat) % DEG_360;
        if (u > DEG_180) u = DEG_360 - u;
        neg = (u > DEG_90);
        if (neg) u = DEG_180 - u;
        rotate(deg_to_rad(u), c, s);
        return abs64(c);
    endfunction

    function automatic logic [22:0] predict_distance(input longint lon1, input longint lat1,
                                                     input longint lon2, input longint lat2);
        bit n1, n2;
        longint unsigned c1, c2, t1, t2, d;
        longint a, ry, rx, z;
        c1 = lat_cos(lat1 * 2, n1);
        c2 = lat_cos(lat2 * 2, n2);
        t1 = half_sin_sq(lat2 - lat1);
        t2 = (((c1 * c2) >> 30) * half_sin_sq(lon2 - lon1)) >> 30;
        a = (n1 != n2) ? longint'(t1) - longint'(t2) : longint'(t1) + longint'(t2);
        if (a < 0) a = 0;
        if (a > Q30_ONE) a = Q30_ONE;
        ry = floor_sqrt(longint'(a) << 30);
        rx = floor_sqrt((Q30_ONE - a) << 30);
        z = vector_angle(ry, rx);
        if (z < 0) z = 0;
        if (z > HALF_PI_Q30) z = HALF_PI_Q30;
        d = (longint'(z) * 2 * 6373 + (64'd1 << 21)) >> 22;
        return d[22:0];
    endfunction

    assign o_pending = dist_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_pt.valid && i_pt.ready)
                dist_queue.push_back(predict_distance(i_pt.lon_a, i_pt.lat_a,
                                                      i_pt.lon_b, i_pt.lat_b));
            if (o_dist.valid && o_dist.ready) begin
                if (dist_queue.size() == 0) begin
                    $display("%0t: unexpected distance %0d", $time, o_dist.distance);
                    o_errors <= o_errors + 1;
                end else if (dist_queue[0] !== o_dist.distance) begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             dist_queue[0], o_dist.distance);
                    o_errors <= o_errors + 1;
                    void'(dist_queue.pop_front());
                end else begin
                    void'(dist_queue.pop_front());
                end
            end
        end
    end
endmodule

`default_nettype wire

/* sim/great_circle_distance_tb.sv */
`default_nettype none

module great_circle_distance_tb;
    localparam int CORDIC_STEPS = 24;
    localparam int LATENCY = 2 * CORDIC_STEPS + 43;
    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   idle_count;
    bit   calm;

    gcd_in_if  pt_if();
    gcd_out_if dist_if();

    great_circle_distance #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_if.sink), .o_dist(dist_if.source));

    gcd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_if), .o_dist(dist_if),
        .o_errors(errors), .o_pending(pending));

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random except during the calm stretch.
    always @(posedge i_clk)
        dist_if.ready <= calm || ($urandom_range(99) >= 33);

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (dist_if.valid && dist_if.ready) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [24:0] rand_lon(input int mode);
        case (mode)
            0: return 25'($signed($urandom_range(23592960)) - 11796480);
            1: return 25'($urandom());
            default: return 25'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_lat(input int mode);
        case (mode)
            0: return 24'($signed($urandom_range(11796480)) - 5898240);
            1: return 24'($urandom());
            default: return 24'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic send_point(input logic signed [24:0] lo1, input logic signed [23:0] la1,
                              input logic signed [24:0] lo2, input logic signed [23:0] la2);
        pt_if.valid <= 1'b1;
        pt_if.lon_a <= lo1;
        pt_if.lat_a <= la1;
        pt_if.lon_b <= lo2;
        pt_if.lat_b <= la2;
        do @(posedge i_clk); while (!pt_if.ready);
        if (!calm && $urandom_range(99) < 33) begin
            pt_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
    endtask

    task automatic send_random(input int mode);
        int lm;
        lm = (mode == 3) ? $urandom_range(2) : mode;
        send_point(rand_lon(lm), rand_lat(lm), rand_lon(lm), rand_lat(lm));
    endtask

    initial begin
        i_rst_n = 1'b0;
        calm = 1'b0;
        pt_if.valid = 1'b0;
        pt_if.lon_a = '0;
        pt_if.lat_a = '0;
        pt_if.lon_b = '0;
        pt_if.lat_b = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identical points, antipodes, poles, range ends and encoded angles beyond range.
        send_point(0, 0, 0, 0);
        send_point(0, 0, 25'sd11796480, 0);
        send_point(-25'sd11796480, 0, 25'sd11796480, 0);
        send_point(0, 24'sd5898240, 0, -24'sd5898240);
        send_point(0, 24'sd5898240, 25'sd1000000, 24'sd5898240);
        send_point(25'sd11796480, 24'sd5898240, -25'sd11796480, -24'sd5898240);
        send_point(0, -24'sd5898240, 0, -24'sd5898240);
        send_point(-25'sd16777216, -24'sd8388608, 25'sd16777215, 24'sd8388607);
        send_point(25'sd16777215, 24'sd8388607, -25'sd16777216, -24'sd8388608);
        send_point(0, 24'sd8000000, 25'sd3000000, -24'sd2000000);
        send_point(0, 24'sd7000000, 25'sd5000000, 24'sd100);
        send_point(0, 0, 25'sd5898240, 0);
        send_point(0, 0, 0, 24'sd1);
        send_point(0, 0, 25'sd1, 0);
        send_point(25'sd6553600, 24'sd3276800, 25'sd6553601, 24'sd3276800);
        send_point(-25'sd1, -24'sd1, 25'sd1, 24'sd1);
        send_point(0, 24'sd5898240, 25'sd11796480, 24'sd5898239);

        for (int i = 0; i < 900; i++) send_random(3);

        // Hold off until the pipeline has drained.
        pt_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        calm = 1'b1;
        for (int i = 0; i < 300; i++) send_random(0);
        calm = 1'b0;
        for (int i = 0; i < 600; i++) send_random(3);
        pt_if.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire

/* great_circle_distance.f */
rtl/core/gcd_pkg.sv
rtl/core/gcd_if.sv
rtl/core/gcd_rot_cell.sv
rtl/core/gcd_vec_cell.sv
rtl/core/gcd_sqrt_cell.sv
rtl/core/great_circle_distance.sv
sim/gcd_checker.sv
sim/great_circle_distance_tb.sv
